@@ hdl/fsde_pkg.sv @@
`timescale 1ns / 1ps
// types, codes and helper functions shared by the float switch debounce block
// no dependencies

package fsde_pkg;

	localparam int unsigned NUM_TANKS    = 4;
	localparam int unsigned NUM_SWITCHES = 8;
	localparam int unsigned EDGE_W       = 16;
	localparam int unsigned LEVEL_W      = 3;

	typedef enum logic [1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_QUERY  = 2'd1,
		CMD_CLEAR  = 2'd2
	} cmd_t;

	localparam logic [LEVEL_W-1:0] LEVEL_EMPTY    = 3'd0;
	localparam logic [LEVEL_W-1:0] LEVEL_MID      = 3'd1;
	localparam logic [LEVEL_W-1:0] LEVEL_FULL     = 3'd2;
	localparam logic [LEVEL_W-1:0] LEVEL_UNDEF    = 3'd3;
	localparam logic [LEVEL_W-1:0] LEVEL_DISABLED = 3'd4;

	localparam logic [NUM_TANKS-1:0] TANK_ENABLE_RESET = 4'hF;

	typedef logic [NUM_TANKS-1:0] tank_enable_t;

	typedef struct packed {
		logic [1:0]              cmd;
		logic [NUM_SWITCHES-1:0] switch_pins;
		logic [NUM_SWITCHES-1:0] event_mask;
	} item_t;

	typedef struct packed {
		logic [NUM_SWITCHES-1:0] latched_events;
		logic                    mask_hit;
		logic [EDGE_W-1:0]       switch_edges;
		logic [LEVEL_W-1:0]      tank0_level;
		logic [LEVEL_W-1:0]      tank1_level;
		logic [LEVEL_W-1:0]      tank2_level;
		logic [LEVEL_W-1:0]      tank3_level;
	} result_t;

	// each tank enable bit covers its two switches
	function automatic logic [NUM_SWITCHES-1:0] widen_enable(input tank_enable_t en);
		logic [NUM_SWITCHES-1:0] m;
		m = '0;
		for (int k = 0; k < NUM_TANKS; k++) begin
			m[2*k]   = en[k];
			m[2*k+1] = en[k];
		end
		return m;
	endfunction

	// switch i on goes to bit 2i, off to bit 2i+1
	function automatic logic [EDGE_W-1:0] spread_edges(input logic [NUM_SWITCHES-1:0] on,
			input logic [NUM_SWITCHES-1:0] off);
		logic [EDGE_W-1:0] e;
		e = '0;
		for (int i = 0; i < NUM_SWITCHES; i++) begin
			e[2*i]   = on[i];
			e[2*i+1] = off[i];
		end
		return e;
	endfunction

	function automatic logic [LEVEL_W-1:0] decode_level(input logic enabled, input logic top,
			input logic bot);
		logic [LEVEL_W-1:0] lvl;
		if (!enabled) begin
			lvl = LEVEL_DISABLED;
		end else begin
			case ({top, bot})
				2'b00:   lvl = LEVEL_EMPTY;
				2'b01:   lvl = LEVEL_MID;
				2'b11:   lvl = LEVEL_FULL;
				default: lvl = LEVEL_UNDEF;
			endcase
		end
		return lvl;
	endfunction

endpackage

@@ hdl/fsde_chan_if.sv @@
`timescale 1ns / 1ps
// valid/ready channel carrying one payload of a given type
// used with payload types from fsde_pkg

interface fsde_chan_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ hdl/float_switch_debounce_events_unit.sv @@
`timescale 1ns / 1ps
// top level of the float switch debouncer with sticky tank events
// uses fsde_pkg, fsde_chan_if and a chain of fsde_cell stages

// Takes one request per clock and delivers its result from an output register in
// the cycle after acceptance; a new request is taken whenever that register is
// empty or being read in the same cycle, so throughput is one per cycle. Sample
// history is a chain of DEBOUNCE cells that shift on each sample request; a switch
// edge is reported when the new word matches the DEBOUNCE-1 newest cells and the
// oldest cell differs. The user must write tank enable only while idle; the block does not enforce it.

module float_switch_debounce_events_unit #(
	parameter int unsigned DEBOUNCE = 4
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	fsde_chan_if.sink                               item,
	fsde_chan_if.source                             result,
	fsde_chan_if.sink                               cfg
);

	localparam logic [DEBOUNCE-1:0] LAST_BIT = DEBOUNCE'(1) << (DEBOUNCE - 1);

	fsde_pkg::tank_enable_t                tank_enable_q;
	logic [fsde_pkg::NUM_SWITCHES-1:0]     pending_q;
	logic                                  out_valid_q;
	fsde_pkg::result_t                     out_data_q;

	logic [fsde_pkg::NUM_SWITCHES-1:0]     en_mask;
	logic [fsde_pkg::NUM_SWITCHES-1:0]     word;
	logic                                  accept;
	logic                                  is_sample;
	logic [fsde_pkg::NUM_SWITCHES-1:0]     hist [DEBOUNCE];
	logic [DEBOUNCE-1:0]                   match;
	logic                                  stable;
	logic [fsde_pkg::NUM_SWITCHES-1:0]     oldest;
	logic [fsde_pkg::NUM_SWITCHES-1:0]     on_bits;
	logic [fsde_pkg::NUM_SWITCHES-1:0]     off_bits;
	logic [fsde_pkg::EDGE_W-1:0]           edges;
	logic [fsde_pkg::NUM_SWITCHES-1:0]     pending_d;
	logic                                  hit;
	fsde_pkg::result_t                     res_d;

	assign cfg.ready  = 1'b1;
	assign item.ready = !out_valid_q || result.ready;
	assign accept     = item.valid && item.ready;
	assign is_sample  = (item.data.cmd == fsde_pkg::CMD_SAMPLE);

	assign en_mask = fsde_pkg::widen_enable(tank_enable_q);
	assign word    = ~item.data.switch_pins & en_mask;

	genvar gi;
	generate
		for (gi = 0; gi < DEBOUNCE; gi++) begin : g_cell
			fsde_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (accept && is_sample),
				.word_in  ((gi == 0) ? word : hist[(gi == 0) ? 0 : gi - 1]),
				.cmp_word (word),
				.word_q   (hist[gi]),
				.match    (match[gi])
			);
		end
	endgenerate

	// the oldest cell only has to differ, so it is left out of the match
	assign stable   = &(match | LAST_BIT);
	assign oldest   = hist[DEBOUNCE-1];
	assign on_bits  = ~oldest & word & en_mask;
	assign off_bits = oldest & ~word & en_mask;

	always_comb begin
		edges     = '0;
		hit       = 1'b0;
		pending_d = pending_q;
		case (item.data.cmd)
			fsde_pkg::CMD_SAMPLE: begin
				if (stable && (oldest != word)) begin
					edges = fsde_pkg::spread_edges(on_bits, off_bits);
				end
				// full on a top switch rising, empty on a bottom switch falling
				for (int k = 0; k < fsde_pkg::NUM_TANKS; k++) begin
					if (edges[4*k]) begin
						pending_d[2*k] = 1'b1;
					end
					if (edges[4*k+3]) begin
						pending_d[2*k+1] = 1'b1;
					end
				end
			end
			fsde_pkg::CMD_QUERY: begin
				hit = |(pending_q & item.data.event_mask);
			end
			fsde_pkg::CMD_CLEAR: begin
				hit       = |(pending_q & item.data.event_mask);
				pending_d = pending_q & ~item.data.event_mask;
			end
			default: begin
				hit = 1'b0;
			end
		endcase

		res_d.latched_events = pending_d;
		res_d.mask_hit       = hit;
		res_d.switch_edges   = edges;
		res_d.tank0_level    = fsde_pkg::decode_level(tank_enable_q[0], word[0], word[1]);
		res_d.tank1_level    = fsde_pkg::decode_level(tank_enable_q[1], word[2], word[3]);
		res_d.tank2_level    = fsde_pkg::decode_level(tank_enable_q[2], word[4], word[5]);
		res_d.tank3_level    = fsde_pkg::decode_level(tank_enable_q[3], word[6], word[7]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tank_enable_q <= fsde_pkg::TANK_ENABLE_RESET;
			pending_q     <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				tank_enable_q <= cfg.data;
			end
			if (accept) begin
				pending_q   <= pending_d;
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= res_d;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_data_q;

endmodule

@@ hdl/fsde_cell.sv @@
`timescale 1ns / 1ps
// one history stage: holds a sample word, shifts it on to the next stage
// and compares it against the incoming word; uses fsde_pkg

module fsde_cell (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 shift_en,
	input  logic [fsde_pkg::NUM_SWITCHES-1:0]    word_in,
	input  logic [fsde_pkg::NUM_SWITCHES-1:0]    cmp_word,
	output logic [fsde_pkg::NUM_SWITCHES-1:0]    word_q,
	output logic                                 match
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
		end else if (shift_en) begin
			word_q <= word_in;
		end
	end

	assign match = (word_q == cmp_word);

endmodule

@@ tb/fsde_checker.sv @@
`timescale 1ns / 1ps
// watches the request, result and tank enable channels of the float switch block,
// predicts every result and compares it field by field; uses fsde_pkg

module fsde_checker #(
	parameter int unsigned DEBOUNCE = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	input  logic                   item_ready,
	input  fsde_pkg::item_t        item_data,
	input  logic                   result_valid,
	input  logic                   result_ready,
	input  fsde_pkg::result_t      result_data,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  fsde_pkg::tank_enable_t cfg_data,
	output int                     fail_count,
	output int                     outstanding,
	output int                     checked_count,
	output int                     edge_count
);

	logic [fsde_pkg::NUM_SWITCHES-1:0] history [DEBOUNCE];
	logic [fsde_pkg::NUM_SWITCHES-1:0] sticky_events;
	fsde_pkg::tank_enable_t            tank_en;
	fsde_pkg::result_t                 owed_results [$];

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch on result %0d: %s", $time, checked_count, msg);
		fail_count++;
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want)
			report_mismatch($sformatf("%s expected 0x%0h, got 0x%0h", name, want, got));
	endtask

	// advances the predicted history and events by one request
	task automatic compute_switch_result(input fsde_pkg::item_t req,
			output fsde_pkg::result_t res);
		logic [fsde_pkg::NUM_SWITCHES-1:0] en_sw;
		logic [fsde_pkg::NUM_SWITCHES-1:0] word;
		logic [fsde_pkg::NUM_SWITCHES-1:0] on;
		logic [fsde_pkg::NUM_SWITCHES-1:0] off;
		logic [fsde_pkg::NUM_SWITCHES-1:0] oldest;
		logic [fsde_pkg::EDGE_W-1:0]       edges;
		logic [fsde_pkg::LEVEL_W-1:0]      lvl [fsde_pkg::NUM_TANKS];
		logic                              stable;
		logic                              hit;
		for (int k = 0; k < fsde_pkg::NUM_TANKS; k++) begin
			en_sw[2*k]   = tank_en[k];
			en_sw[2*k+1] = tank_en[k];
		end
		word  = ~req.switch_pins & en_sw;
		edges = '0;
		hit   = 1'b0;
		case (req.cmd)
			fsde_pkg::CMD_SAMPLE: begin
				stable = 1'b1;
				oldest = history[DEBOUNCE-1];
				for (int i = 0; i + 1 < DEBOUNCE; i++) begin
					if (history[i] != word)
						stable = 1'b0;
				end
				if (stable && oldest != word) begin
					on  = ~oldest & word & en_sw;
					off = oldest & ~word & en_sw;
					for (int i = 0; i < fsde_pkg::NUM_SWITCHES; i++) begin
						edges[2*i]   = on[i];
						edges[2*i+1] = off[i];
					end
				end
				for (int i = DEBOUNCE - 1; i > 0; i--)
					history[i] = history[i-1];
				history[0] = word;
				// top switch on latches full, bottom switch off latches empty
				for (int k = 0; k < fsde_pkg::NUM_TANKS; k++) begin
					if (edges[4*k])
						sticky_events[2*k] = 1'b1;
					if (edges[4*k+3])
						sticky_events[2*k+1] = 1'b1;
				end
			end
			fsde_pkg::CMD_QUERY: begin
				hit = |(sticky_events & req.event_mask);
			end
			fsde_pkg::CMD_CLEAR: begin
				hit = |(sticky_events & req.event_mask);
				sticky_events = sticky_events & ~req.event_mask;
			end
			default: ;
		endcase
		for (int k = 0; k < fsde_pkg::NUM_TANKS; k++) begin
			if (!tank_en[k]) begin
				lvl[k] = fsde_pkg::LEVEL_DISABLED;
			end else begin
				case ({word[2*k], word[2*k+1]})
					2'b00:   lvl[k] = fsde_pkg::LEVEL_EMPTY;
					2'b01:   lvl[k] = fsde_pkg::LEVEL_MID;
					2'b11:   lvl[k] = fsde_pkg::LEVEL_FULL;
					default: lvl[k] = fsde_pkg::LEVEL_UNDEF;
				endcase
			end
		end
		res.latched_events = sticky_events;
		res.mask_hit       = hit;
		res.switch_edges   = edges;
		res.tank0_level    = lvl[0];
		res.tank1_level    = lvl[1];
		res.tank2_level    = lvl[2];
		res.tank3_level    = lvl[3];
	endtask

	initial begin
		fail_count    = 0;
		checked_count = 0;
		edge_count    = 0;
		outstanding   = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		fsde_pkg::result_t want;
		fsde_pkg::result_t fresh;
		if (!arst_n) begin
			for (int i = 0; i < DEBOUNCE; i++)
				history[i] = '0;
			sticky_events = '0;
			tank_en       = fsde_pkg::TANK_ENABLE_RESET;
			owed_results.delete();
			outstanding = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				tank_en = cfg_data;
			if (result_valid && result_ready) begin
				if (owed_results.size() == 0) begin
					report_mismatch("result with no request waiting");
				end else begin
					want = owed_results.pop_front();
					check_field("latched_events", 16'(want.latched_events),
						16'(result_data.latched_events));
					check_field("mask_hit", 16'(want.mask_hit), 16'(result_data.mask_hit));
					check_field("switch_edges", want.switch_edges, result_data.switch_edges);
					check_field("tank0_level", 16'(want.tank0_level), 16'(result_data.tank0_level));
					check_field("tank1_level", 16'(want.tank1_level), 16'(result_data.tank1_level));
					check_field("tank2_level", 16'(want.tank2_level), 16'(result_data.tank2_level));
					check_field("tank3_level", 16'(want.tank3_level), 16'(result_data.tank3_level));
					if (want.switch_edges != '0)
						edge_count++;
				end
				checked_count++;
			end
			if (item_valid && item_ready) begin
				compute_switch_result(item_data, fresh);
				owed_results.push_back(fresh);
			end
			outstanding = owed_results.size();
		end
	end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// top of the float switch debounce testbench: clock, reset, request and enable stimulus
// depends on fsde_pkg, fsde_chan_if, fsde_checker and the block itself

module testbench;

	localparam int unsigned DEBOUNCE   = 4;
	localparam logic [1:0]  CMD_UNUSED = 2'd3;
	localparam int          NUM_PHASES = 8;

	logic clk;
	logic arst_n;

	fsde_chan_if #(.payload_t(fsde_pkg::item_t))        item_ch ();
	fsde_chan_if #(.payload_t(fsde_pkg::result_t))      result_ch ();
	fsde_chan_if #(.payload_t(fsde_pkg::tank_enable_t)) cfg_ch ();

	int fail_count;
	int outstanding;
	int checked_count;
	int edge_count;
	int burst_left;
	int items_sent;
	int stall_cycle;
	logic [fsde_pkg::NUM_SWITCHES-1:0] held_pins;

	float_switch_debounce_events_unit #(.DEBOUNCE(DEBOUNCE)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	fsde_checker #(.DEBOUNCE(DEBOUNCE)) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_ch.valid),
		.item_ready    (item_ch.ready),
		.item_data     (item_ch.data),
		.result_valid  (result_ch.valid),
		.result_ready  (result_ch.ready),
		.result_data   (result_ch.data),
		.cfg_valid     (cfg_ch.valid),
		.cfg_ready     (cfg_ch.ready),
		.cfg_data      (cfg_ch.data),
		.fail_count    (fail_count),
		.outstanding   (outstanding),
		.checked_count (checked_count),
		.edge_count    (edge_count)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// receiver stall pattern rotates through four behaviors
	always @(negedge clk) begin
		stall_cycle <= stall_cycle + 1;
		case ((stall_cycle / 150) % 4)
			0:       result_ch.ready <= 1'b1;
			1:       result_ch.ready <= ($urandom_range(0, 3) != 0);
			2:       result_ch.ready <= 1'($urandom_range(0, 1));
			default: result_ch.ready <= ((stall_cycle % 8) < 3);
		endcase
	end

	function automatic fsde_pkg::item_t mk(input logic [1:0] cmd, input logic [7:0] pins,
			input logic [7:0] mask);
		fsde_pkg::item_t it;
		it.cmd         = cmd;
		it.switch_pins = pins;
		it.event_mask  = mask;
		return it;
	endfunction

	function automatic fsde_pkg::item_t event_request();
		logic [7:0] mask;
		case ($urandom_range(0, 5))
			0:       mask = 8'hFF;
			1:       mask = 8'h00;
			2, 3:    mask = 8'h01 << $urandom_range(0, 7);
			default: mask = 8'($urandom);
		endcase
		return mk($urandom_range(0, 1) ? fsde_pkg::CMD_CLEAR : fsde_pkg::CMD_QUERY,
			8'($urandom), mask);
	endfunction

	task automatic send_item(input fsde_pkg::item_t it);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			// some bursts follow straight on with no gap
			if ($urandom_range(0, 3) != 0) begin
				item_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
		end
		item_ch.valid <= 1'b1;
		item_ch.data  <= it;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		@(negedge clk);
		burst_left--;
		items_sent++;
	endtask

	// sender holds off until every owed result is back
	task automatic wait_idle();
		item_ch.valid <= 1'b0;
		burst_left = 0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_enable(input fsde_pkg::tank_enable_t en);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= en;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic run_directed();
		send_item(mk(CMD_UNUSED, 8'h00, 8'hFF));
		send_item(mk(fsde_pkg::CMD_QUERY, 8'h00, 8'hFF));
		send_item(mk(fsde_pkg::CMD_CLEAR, 8'hFF, 8'hFF));
		// all switches on long enough to give on edges and full events
		repeat (4) send_item(mk(fsde_pkg::CMD_SAMPLE, 8'h00, 8'h00));
		send_item(mk(fsde_pkg::CMD_QUERY, 8'hFF, 8'h01));
		send_item(mk(fsde_pkg::CMD_QUERY, 8'hFF, 8'hAA));
		send_item(mk(fsde_pkg::CMD_CLEAR, 8'h00, 8'h01));
		// top only, then bottom only: a bounce with no edges
		send_item(mk(fsde_pkg::CMD_SAMPLE, 8'hAA, 8'hFF));
		send_item(mk(fsde_pkg::CMD_SAMPLE, 8'h55, 8'h00));
		repeat (4) send_item(mk(fsde_pkg::CMD_SAMPLE, 8'hFF, 8'hFF));
		send_item(mk(fsde_pkg::CMD_QUERY, 8'h00, 8'hFF));
		send_item(mk(fsde_pkg::CMD_CLEAR, 8'h55, 8'hAA));
		send_item(mk(fsde_pkg::CMD_CLEAR, 8'hAA, 8'hFF));
		send_item(mk(fsde_pkg::CMD_QUERY, 8'h00, 8'hFF));
		send_item(mk(CMD_UNUSED, 8'hFF, 8'h00));
		repeat (4) send_item(mk(fsde_pkg::CMD_SAMPLE, 8'h00, 8'hFF));
	endtask

	task automatic run_random(input int count);
		int sent;
		int pick;
		logic [7:0] pins;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				// a steady run, not always long enough to pass the debounce, sometimes interleaved
				if ($urandom_range(0, 2) == 0) begin
					pins = 8'($urandom);
				end else begin
					pins = held_pins;
					repeat ($urandom_range(1, 3)) pins[$urandom_range(0, 7)] ^= 1'b1;
				end
				repeat ($urandom_range(2, 7)) begin
					if ($urandom_range(0, 5) == 0) begin
						send_item(event_request());
						sent++;
					end
					send_item(mk(fsde_pkg::CMD_SAMPLE, pins, 8'($urandom)));
					sent++;
				end
				held_pins = pins;
			end else if (pick < 75) begin
				repeat ($urandom_range(1, 3)) begin
					send_item(mk(fsde_pkg::CMD_SAMPLE, 8'($urandom), 8'($urandom)));
					sent++;
				end
			end else if (pick < 95) begin
				send_item(event_request());
				sent++;
			end else begin
				send_item(mk(CMD_UNUSED, 8'($urandom), 8'($urandom)));
				sent++;
			end
		end
	endtask

	initial begin
		fsde_pkg::tank_enable_t phase_en [NUM_PHASES];
		arst_n          = 1'b0;
		item_ch.valid   = 1'b0;
		item_ch.data    = '0;
		result_ch.ready = 1'b0;
		cfg_ch.valid    = 1'b0;
		cfg_ch.data     = '0;
		stall_cycle     = 0;
		burst_left      = 0;
		items_sent      = 0;
		held_pins       = 8'hFF;
		phase_en = '{4'h0, 4'hF, 4'h5, 4'hA, 4'($urandom), 4'($urandom), 4'h1, 4'h8};
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		run_directed();
		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_idle();
			write_enable(phase_en[p]);
			run_random(100);
			if (p == 2)
				wait_idle();
			run_random(100);
		end
		wait_idle();
		write_enable(fsde_pkg::TANK_ENABLE_RESET);
		run_random(20);
		wait_idle();
		repeat (5) @(negedge clk);
		$display("sent %0d requests over %0d tank enable settings", items_sent, NUM_PHASES + 1);
		$display("checked %0d results, %0d of them carrying debounced edges",
			checked_count, edge_count);
		if (fail_count == 0 && outstanding == 0) begin
			$display("float_switch_debounce_events_unit test passed");
		end else begin
			$display("float_switch_debounce_events_unit test failed");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("timeout with %0d results still owed", outstanding);
		$display("float_switch_debounce_events_unit test failed");
		$finish;
	end

endmodule
